[rtl/core/sine_plasma_pixel_generator_macros.svh]
// assertion macros for the sine plasma pixel generator checker
// needs clk and rst in the scope where the macros are used
`ifndef SINE_PLASMA_PIXEL_GENERATOR_MACROS_SVH
`define SINE_PLASMA_PIXEL_GENERATOR_MACROS_SVH

// condition implies consequence in the same cycle
`define SPP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the following cycle
`define SPP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/spp_pkg.sv]
// shared types, constants and the sine table for the plasma pixel generator
// no dependencies
`default_nettype none

package spp_pkg;

  localparam int FRAME_WIDTH  = 320;
  localparam int FRAME_HEIGHT = 240;
  localparam int ADDR_W       = 17;
  localparam int COL_W        = 9;
  localparam int ROW_W        = 8;
  localparam int COLOR_W      = 5;
  localparam int TSTEP_W      = 10;

  // time step = ms / 20 = (ms >> 2) / 5, divide by five as a reciprocal multiply
  localparam int          TSTEP_SHIFT       = 2;
  localparam logic [31:0] TSTEP_RECIP       = 32'hCCCC_CCCD;
  localparam int          TSTEP_RECIP_SHIFT = 34;
  localparam int          TSTEP_PROD_W      = TSTEP_RECIP_SHIFT + TSTEP_W;

  localparam int MID_DEPTH    = 4;
  localparam int OUT_DEPTH    = 4;

  typedef enum logic [2:0] {
    REG_FRAME_TIME   = 3'd0,
    REG_PANEL_LEFT   = 3'd1,
    REG_PANEL_TOP    = 3'd2,
    REG_PANEL_WIDTH  = 3'd3,
    REG_PANEL_HEIGHT = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [9:0] left;
    logic [8:0] top;
    logic [9:0] width;
    logic [8:0] height;
  } panel_cfg_t;

  typedef struct packed {
    logic [3:0][7:0]    wave_idx;
    logic [ADDR_W-1:0]  pixel_address;
    logic               write_enable;
    logic               frame_last;
  } pixel_job_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] color_index;
    logic               write_enable;
    logic               frame_last;
  } pixel_out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // trunc(127*sin(pi*k/128)) for the first quadrant
  localparam logic [6:0] QUARTER_SINE [0:64] = '{
    7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd15,  7'd18,  7'd21,  7'd24,  7'd27,
    7'd30,  7'd33,  7'd36,  7'd39,  7'd42,  7'd45,  7'd48,  7'd51,  7'd54,  7'd57,
    7'd59,  7'd62,  7'd65,  7'd67,  7'd70,  7'd73,  7'd75,  7'd78,  7'd80,  7'd82,
    7'd85,  7'd87,  7'd89,  7'd91,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd103,
    7'd105, 7'd107, 7'd108, 7'd110, 7'd112, 7'd113, 7'd114, 7'd116, 7'd117, 7'd118,
    7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd123, 7'd124, 7'd125, 7'd125, 7'd126,
    7'd126, 7'd126, 7'd126, 7'd126, 7'd127
  };

  function automatic logic signed [7:0] sine_lookup(input logic [7:0] i);
    logic [6:0] q;
    logic [6:0] k;
    logic [7:0] mag;
    q   = i[6:0];
    k   = (q <= 7'd64) ? q : 7'(8'd128 - {1'b0, q});
    mag = {1'b0, QUARTER_SINE[k]};
    return i[7] ? $signed(-mag) : $signed(mag);
  endfunction

endpackage

`default_nettype wire

[rtl/core/spp_tstep.sv]
// time step unit: frame time in ms divided by 20 by a reciprocal multiply
// depends on spp_pkg
`default_nettype none

module spp_tstep import spp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        value,
  output logic               busy,
  output logic [TSTEP_W-1:0] tstep
);

  logic [31-TSTEP_SHIFT:0]  quarter_ms;
  logic [TSTEP_PROD_W-1:0]  prod;
  logic                     pending;

  // only the low quotient bits are formed, the index math wraps anyway
  assign prod = TSTEP_PROD_W'(quarter_ms) * TSTEP_PROD_W'(TSTEP_RECIP);
  assign busy = pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      tstep   <= '0;
    end else if (start) begin
      pending <= 1'b1;
    end else if (pending) begin
      pending <= 1'b0;
      tstep   <= prod[TSTEP_PROD_W-1:TSTEP_RECIP_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (start) quarter_ms <= value[31:TSTEP_SHIFT];
  end

endmodule

`default_nettype wire

[rtl/core/spp_front.sv]
// front end: raster position, wave indices, address and panel classification
// depends on spp_pkg
`default_nettype none

module spp_front import spp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               restart,
  input  logic [TSTEP_W-1:0] tstep,
  input  panel_cfg_t         panel,
  output pixel_job_t         job
);

  logic [COL_W-1:0]  raster_column;
  logic [ROW_W-1:0]  raster_row;
  logic [COL_W-1:0]  raster_column_next;
  logic [ROW_W-1:0]  raster_row_next;
  logic [COL_W-1:0]  x;
  logic [ROW_W-1:0]  y;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic [8:0]        sum3;
  logic [9:0]        t3;
  logic [9:0]        sum4;
  logic signed [11:0] xs, left_s, right_s;
  logic signed [10:0] ys, top_s, bottom_s;
  logic              in_panel;

  assign x = restart ? '0 : raster_column;
  assign y = restart ? '0 : raster_row;

  assign sum3 = x + 9'(y) + tstep[8:0];
  assign t3   = tstep + {tstep[8:0], 1'b0};
  assign sum4 = {x, 1'b0} - 10'(y) + t3;

  // x stays below the frame width, so clamping the edges changes nothing here
  assign xs       = $signed({3'b000, x});
  assign left_s   = $signed({{2{panel.left[9]}}, panel.left});
  assign right_s  = left_s + $signed({2'b00, panel.width});
  assign ys       = $signed({3'b000, y});
  assign top_s    = $signed({{2{panel.top[8]}}, panel.top});
  assign bottom_s = top_s + $signed({2'b00, panel.height});
  assign in_panel = (xs >= left_s) && (xs < right_s) && (ys >= top_s) && (ys < bottom_s);

  always_comb begin
    job.wave_idx[0]   = x[7:0] + tstep[7:0];
    job.wave_idx[1]   = y + {tstep[6:0], 1'b0};
    job.wave_idx[2]   = sum3[8:1];
    job.wave_idx[3]   = sum4[9:2];
    job.pixel_address = ADDR_W'(y) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(x);
    job.write_enable  = !in_panel;
    job.frame_last    = (x == COL_W'(FRAME_WIDTH - 1)) && (y == ROW_W'(FRAME_HEIGHT - 1));
  end

  assign col_inc = {1'b0, x} + 1'b1;
  assign row_inc = {1'b0, y} + 1'b1;

  always_comb begin
    raster_column_next = col_inc[COL_W-1:0];
    raster_row_next    = y;
    if (col_inc >= (COL_W+1)'(FRAME_WIDTH)) begin
      raster_column_next = '0;
      raster_row_next    = (row_inc >= (ROW_W+1)'(FRAME_HEIGHT)) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raster_column <= '0;
      raster_row    <= '0;
    end else if (accept) begin
      raster_column <= raster_column_next;
      raster_row    <= raster_row_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/spp_queue.sv]
// short job queue between the front end and the back end
// depends on spp_pkg
`default_nettype none

module spp_queue import spp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pixel_job_t    push_job,
  input  logic          pop,
  output pixel_job_t    head_job,
  output queue_status_t status
);

  localparam int PTR_W = $clog2(MID_DEPTH);
  localparam int CNT_W = $clog2(MID_DEPTH + 1);

  pixel_job_t       entries [MID_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = count == CNT_W'(MID_DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      if (do_pop) rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_job;
  end

endmodule

`default_nettype wire

[rtl/core/spp_back.sv]
// back end: sine lookups, sum stage, colour mapping and the result queue
// depends on spp_pkg
`default_nettype none

module spp_back import spp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  pixel_job_t job,
  output logic       job_take,
  input  logic       res_pop,
  output logic       res_empty,
  output pixel_out_t res
);

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 2);

  logic               s1_valid;
  logic signed [9:0]  s1_sum;
  logic [ADDR_W-1:0]  s1_addr;
  logic               s1_we;
  logic               s1_last;
  logic signed [9:0]  sum;
  logic signed [9:0]  adj;
  logic signed [9:0]  quarter;
  logic [9:0]         plasma;
  logic [11:0]        prod;
  pixel_out_t         s1_out;

  pixel_out_t         entries [OUT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  // one slot is held back for the beat still in the sum stage
  assign job_take = job_valid && ((count + CNT_W'(s1_valid)) < CNT_W'(OUT_DEPTH));

  always_comb begin
    sum = 10'(sine_lookup(job.wave_idx[0])) + 10'(sine_lookup(job.wave_idx[1]))
        + 10'(sine_lookup(job.wave_idx[2])) + 10'(sine_lookup(job.wave_idx[3]));
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= job_take;
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      s1_sum  <= sum;
      s1_addr <= job.pixel_address;
      s1_we   <= job.write_enable;
      s1_last <= job.frame_last;
    end
  end

  // divide by four rounding toward zero
  assign adj     = s1_sum + (s1_sum[9] ? 10'sd3 : 10'sd0);
  assign quarter = adj >>> 2;
  assign plasma  = 10'(quarter + 10'sd128);
  assign prod    = {plasma[7:0], 4'b0000} - {4'b0000, plasma[7:0]};

  always_comb begin
    s1_out.pixel_address = s1_addr;
    s1_out.color_index   = COLOR_W'(2) + {1'b0, prod[11:8]};
    s1_out.write_enable  = s1_we;
    s1_out.frame_last    = s1_last;
  end

  assign res_empty = count == '0;
  assign do_pop    = res_pop && !res_empty;
  assign res       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s1_valid) wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      if (do_pop) rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      count <= count + CNT_W'(s1_valid) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) entries[wr_ptr] <= s1_out;
  end

endmodule

`default_nettype wire

[rtl/core/sine_plasma_pixel_generator.sv]
// top level of the sine plasma pixel generator: register port and wiring
// depends on spp_pkg, spp_tstep, spp_front, spp_queue, spp_back
//
//   channel   handshake            beat contents
//   input     push / full          restart
//   result    empty / pop          pixel_address, color_index, write_enable, frame_last
//   config    psel/penable/pwrite  5 registers at byte address 4*i, 32 bit data
//
// one pixel per cycle sustained while full stays low; a result passes through the job
// queue, the sine sum stage and the result queue before it is on the ports
// writing frame_time_ms holds full high for one cycle while the time step is
// formed by a reciprocal multiply
// a stalled result side backs up through the result queue and the job queue
// synchronous reset; raster at (0,0), registers at their defaults
`default_nettype none

module sine_plasma_pixel_generator import spp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                restart,
  output logic                empty,
  input  logic                pop,
  output logic [ADDR_W-1:0]   pixel_address,
  output logic [COLOR_W-1:0]  color_index,
  output logic                write_enable,
  output logic                frame_last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [31:0]        frame_time_ms;
  panel_cfg_t         panel;
  logic               cfg_wr;
  reg_index_t         reg_idx;
  logic               tstep_busy;
  logic [TSTEP_W-1:0] tstep;
  logic               accept;
  pixel_job_t         front_job;
  pixel_job_t         head_job;
  queue_status_t      qstat;
  logic               job_take;
  pixel_out_t         res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time_ms <= '0;
      panel.left    <= 10'd24;
      panel.top     <= 9'd24;
      panel.width   <= 10'd272;
      panel.height  <= 9'd192;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAME_TIME:   frame_time_ms <= pwdata;
        REG_PANEL_LEFT:   panel.left    <= pwdata[9:0];
        REG_PANEL_TOP:    panel.top     <= pwdata[8:0];
        REG_PANEL_WIDTH:  panel.width   <= pwdata[9:0];
        REG_PANEL_HEIGHT: panel.height  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_TIME:   prdata = frame_time_ms;
      REG_PANEL_LEFT:   prdata = {22'd0, panel.left};
      REG_PANEL_TOP:    prdata = {23'd0, panel.top};
      REG_PANEL_WIDTH:  prdata = {22'd0, panel.width};
      REG_PANEL_HEIGHT: prdata = {23'd0, panel.height};
      default:          prdata = '0;
    endcase
  end

  spp_tstep u_tstep (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_wr && (reg_idx == REG_FRAME_TIME)),
    .value (pwdata),
    .busy  (tstep_busy),
    .tstep (tstep)
  );

  assign full   = qstat.full || tstep_busy;
  assign accept = push && !full;

  spp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .restart (restart),
    .tstep   (tstep),
    .panel   (panel),
    .job     (front_job)
  );

  spp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_job (front_job),
    .pop      (job_take),
    .head_job (head_job),
    .status   (qstat)
  );

  spp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!qstat.empty),
    .job       (head_job),
    .job_take  (job_take),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign pixel_address = res.pixel_address;
  assign color_index   = res.color_index;
  assign write_enable  = res.write_enable;
  assign frame_last    = res.frame_last;

endmodule

`default_nettype wire

[rtl/core/spp_checker.sv]
// port-level checks for the sine plasma pixel generator, bound to the top level
// depends on spp_pkg and sine_plasma_pixel_generator_macros.svh
`default_nettype none

`include "sine_plasma_pixel_generator_macros.svh"

module spp_checker import spp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic [ADDR_W-1:0]  pixel_address,
  input logic [COLOR_W-1:0] color_index,
  input logic               frame_last
);

  // a waiting result holds until popped
  `SPP_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(pixel_address) && $stable(color_index), "result changed while stalled")

  `SPP_ASSERT_NOW(a_color_range, !empty, color_index >= COLOR_W'(2) && color_index <= COLOR_W'(16), "color index out of range")

  `SPP_ASSERT_NOW(a_addr_range, !empty, pixel_address < ADDR_W'(FRAME_WIDTH * FRAME_HEIGHT), "pixel address beyond frame")

  `SPP_ASSERT_NOW(a_last_addr, !empty && frame_last, pixel_address == ADDR_W'(FRAME_WIDTH * FRAME_HEIGHT - 1), "frame end flag on wrong pixel")

endmodule

bind sine_plasma_pixel_generator spp_checker u_spp_checker (.*);

`default_nettype wire

[test/sine_plasma_pixel_generator_tb.sv]
// testbench for the sine plasma pixel generator: raster, palette and panel mask
// needs spp_pkg and the sine_plasma_pixel_generator rtl
module sine_plasma_pixel_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spp_pkg::*;

  localparam logic [2:0] REG_UNUSED_LO = 3'd5;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;
  localparam int         STALL_LIMIT   = 5000;
  localparam int         PRINT_LIMIT   = 30;

  // first quadrant of the palette wave, trunc(127*sin)
  localparam int QUARTER_WAVE [0:64] = '{
      0,   3,   6,   9,  12,  15,  18,  21,  24,  27,  30,  33,  36,
     39,  42,  45,  48,  51,  54,  57,  59,  62,  65,  67,  70,  73,
     75,  78,  80,  82,  85,  87,  89,  91,  94,  96,  98, 100, 102,
    103, 105, 107, 108, 110, 112, 113, 114, 116, 117, 118, 119, 120,
    121, 122, 123, 123, 124, 125, 125, 126, 126, 126, 126, 126, 127
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic restart = 1'b0;
  logic pop = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic full;
  logic empty;
  logic [ADDR_W-1:0] pixel_address;
  logic [COLOR_W-1:0] color_index;
  logic write_enable;
  logic frame_last;
  logic [31:0] prdata;
  logic pready;

  sine_plasma_pixel_generator u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .restart(restart),
    .empty(empty), .pop(pop), .pixel_address(pixel_address),
    .color_index(color_index), .write_enable(write_enable),
    .frame_last(frame_last), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the register file and the raster position
  logic [31:0]    frame_ms_q = 32'd0;
  logic [9:0]     left_q = 10'd24;
  logic [8:0]     top_q = 9'd24;
  logic [9:0]     width_q = 10'd272;
  logic [8:0]     height_q = 9'd192;
  logic [COL_W-1:0] col_q = '0;
  logic [ROW_W-1:0] row_q = '0;

  pixel_out_t pixel_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_settings = 0;
  int pop_hold = 0;
  int idle_cycles = 0;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;

  function automatic int wave(input logic [7:0] i);
    int mag;
    mag = QUARTER_WAVE[(i[6:0] <= 7'd64) ? int'(i[6:0]) : 128 - int'(i[6:0])];
    return i[7] ? -mag : mag;
  endfunction

  function automatic int idle_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 3);
  endfunction

  // expected pixel at the current raster position, then step the raster
  function automatic pixel_out_t next_plasma_pixel(input logic rs);
    pixel_out_t px;
    logic [31:0] x, y, t, i3, i4;
    int sum, plasma, l, tp, r, b;
    bit in_panel;
    if (rs) begin
      col_q = '0;
      row_q = '0;
    end
    x = 32'(col_q);
    y = 32'(row_q);
    t = frame_ms_q / 32'd20;
    i3 = ((x + y + t) & 32'h1FF) >> 1;
    i4 = ((32'd2 * x - y + 32'd3 * t) & 32'h3FF) >> 2;
    sum = wave(8'(x + t)) + wave(8'(y + 32'd2 * t)) + wave(i3[7:0]) + wave(i4[7:0]);
    plasma = sum / 4 + 128;
    l = $signed(left_q);
    tp = $signed(top_q);
    r = l + int'(width_q);
    b = tp + int'(height_q);
    if (l < 0) l = 0;
    if (tp < 0) tp = 0;
    if (r > FRAME_WIDTH) r = FRAME_WIDTH;
    if (b > FRAME_HEIGHT) b = FRAME_HEIGHT;
    in_panel = int'(x) >= l && int'(x) < r && int'(y) >= tp && int'(y) < b;
    px.pixel_address = ADDR_W'(y * FRAME_WIDTH + x);
    px.color_index = COLOR_W'(2 + ((plasma * 15) >>> 8));
    px.write_enable = !in_panel;
    px.frame_last = (x == FRAME_WIDTH - 1) && (y == FRAME_HEIGHT - 1);
    if (int'(col_q) + 1 >= FRAME_WIDTH) begin
      col_q = '0;
      row_q = (int'(row_q) + 1 >= FRAME_HEIGHT) ? '0 : row_q + 1'b1;
    end else begin
      col_q = col_q + 1'b1;
    end
    return px;
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FRAME_TIME:   frame_ms_q = val;
      REG_PANEL_LEFT:   left_q = val[9:0];
      REG_PANEL_TOP:    top_q = val[8:0];
      REG_PANEL_WIDTH:  width_q = val[9:0];
      REG_PANEL_HEIGHT: height_q = val[8:0];
      default: ;
    endcase
    // leave the bus idle before the next register write
    @(posedge clk);
  endtask

  // frame time goes last: its write keeps full high while the step is divided
  task automatic set_panel(input logic [31:0] ms, input logic [31:0] l, input logic [31:0] tp,
                           input logic [31:0] w, input logic [31:0] h);
    cfg_write(REG_PANEL_LEFT, l);
    cfg_write(REG_PANEL_TOP, tp);
    cfg_write(REG_PANEL_WIDTH, w);
    cfg_write(REG_PANEL_HEIGHT, h);
    cfg_write(REG_FRAME_TIME, ms);
    n_settings++;
  endtask

  task automatic push_pixel(input logic rs, input int gap);
    push <= 1'b1;
    restart <= rs;
    @(posedge clk);
    while (full) @(posedge clk);
    pixel_q.push_back(next_plasma_pixel(rs));
    n_sent++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic int tx_gap();
    if (tx_idle && $urandom_range(0, 2) == 0) return idle_gap();
    return 0;
  endfunction

  task automatic test_directed();
    // reset defaults, restart at the first beat and again mid-row
    push_pixel(1'b1, 0);
    push_pixel(1'b0, 0);
    push_pixel(1'b0, 2);
    push_pixel(1'b1, 0);
    wait_drained();
    // panel clamped at left and top covers the whole frame, largest frame time
    set_panel(32'hFFFF_FFFF, 32'(-320), 32'(-240), 32'd640, 32'd480);
    repeat (3) push_pixel(1'b0, 0);
    push_pixel(1'b1, 1);
    wait_drained();
    // empty panel past the frame corner, unused addresses must be ignored
    cfg_write(REG_UNUSED_LO, $urandom);
    cfg_write(REG_UNUSED_HI, $urandom);
    set_panel(32'd19, 32'd320, 32'd240, 32'd0, 32'd0);
    push_pixel(1'b1, 0);
    push_pixel(1'b0, 0);
    wait_drained();
    cfg_write(REG_FRAME_TIME, 32'd20);
    push_pixel(1'b0, 0);
    wait_drained();
    // narrow panel on row 0, bottom edge taken from the unclamped top
    set_panel(32'd12345, 32'd5, 32'(-1), 32'd3, 32'd2);
    push_pixel(1'b1, 0);
    for (int i = 0; i < 9; i++) push_pixel(1'b0, i % 3);
    wait_drained();
  endtask

  task automatic random_panel();
    logic [31:0] ms, l, tp, w, h;
    case ($urandom_range(0, 3))
      0: ms = 32'd0;
      1: ms = 32'hFFFF_FFFF;
      default: ms = $urandom;
    endcase
    l = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 640)) - 32'd320;
    tp = $urandom_range(0, 1) ? 32'($urandom_range(0, 16)) - 32'd8
                              : 32'($urandom_range(0, 480)) - 32'd240;
    w = $urandom_range(0, 640);
    h = $urandom_range(0, 1) ? 32'($urandom_range(0, 12)) : 32'($urandom_range(0, 480));
    set_panel(ms, l, tp, w, h);
  endtask

  // one uninterrupted scan across the end of the first row
  task automatic test_row_wrap();
    random_panel();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    push_pixel(1'b1, 0);
    for (int i = 0; i < FRAME_WIDTH + 8; i++) push_pixel(1'b0, 0);
    wait_drained();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      random_panel();
      tx_idle = (phase % 3) != 2;
      rx_idle = (phase % 2) == 0 || phase == 5;
      for (int i = 0; i < 265; i++) begin
        push_pixel($urandom_range(0, 199) == 0, tx_gap());
        // hold off the sender until the pipeline is empty
        if (phase == 1 && i == 160) wait_drained();
      end
      wait_drained();
    end
  endtask

  // result side: random pop stalls
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else begin
      pop <= 1'b1;
      if (rx_idle && $urandom_range(0, 3) == 0) pop_hold = idle_gap();
    end
  end

  task automatic report_mismatch(input string field, input int want, input int got);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin : result_check
    pixel_out_t want;
    if (!rst && pop && !empty) begin
      n_checked++;
      if (pixel_q.size() == 0) begin
        errors++;
        if (errors <= PRINT_LIMIT)
          $display("%0t: unexpected beat, expected none, got address %0d", $time,
                   pixel_address);
      end else begin
        want = pixel_q.pop_front();
        if (pixel_address !== want.pixel_address)
          report_mismatch("pixel_address", want.pixel_address, pixel_address);
        if (color_index !== want.color_index)
          report_mismatch("color_index", want.color_index, color_index);
        if (write_enable !== want.write_enable)
          report_mismatch("write_enable", want.write_enable, write_enable);
        if (frame_last !== want.frame_last)
          report_mismatch("frame_last", want.frame_last, frame_last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles with no beat, %0d pixels pending", idle_cycles,
               pixel_q.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_row_wrap();
    test_random();
    wait_drained();
    repeat (10) @(posedge clk);
    $display("sent %0d pixels and checked %0d results over %0d register settings,",
             n_sent, n_checked, n_settings);
    $display("including row wraps, panel clamping and random restarts");
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
